@@ src/qcd_running_coupling_core_assert.svh @@
// Assertion macros for the running coupling core.
`ifndef QCD_RUNNING_COUPLING_CORE_ASSERT_SVH
`define QCD_RUNNING_COUPLING_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Implication checked on every rising edge outside reset.
`define QRC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("qcd_running_coupling_core: property violated");

// Condition that must never hold outside reset.
`define QRC_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("qcd_running_coupling_core: forbidden condition seen");

`else

`define QRC_ASSERT(label, clk, rst_n, prop)
`define QRC_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ src/qcd_rc_pkg.sv @@
// Shared constants, types and tables of the running coupling core.
package qcd_rc_pkg;

  // Field and datapath widths
  localparam int MAG_W      = 48;
  localparam int LAM_W      = 22;
  localparam int NF_W       = 3;
  localparam int CFG_W      = 22;
  localparam int ALPHA_W    = 18;
  localparam int ALPHA_FRAC = 16;
  localparam int EXP_W      = 6;
  localparam int LOG_FRAC   = 24;
  localparam int LOG_W      = EXP_W + LOG_FRAC;
  localparam int MANT_W     = 32;
  localparam int LOG_LAT    = LOG_FRAC + 2;
  localparam int L_W        = 32;
  localparam int CORDIC_N   = 24;
  localparam int CW         = 32;
  localparam int ZW         = 28;
  localparam int DW         = 26;
  localparam int BETA_W     = 6;
  localparam int NUM_W      = 47;
  localparam int DEN_W      = 36;
  localparam int DIV_N      = ALPHA_W + 1;
  localparam int DIV_SH_W   = DEN_W + ALPHA_W;

  // Fixed-point constants
  localparam logic [29:0] LN2_Q30    = 30'd744261118;
  localparam logic [29:0] LN2PI_Q30  = 30'd236905672;
  localparam logic [29:0] C12PI_Q24  = 30'd632486142;
  localparam logic [DW-1:0] HALFPI_Q24 = 26'd26353589;

  // Register reset values
  localparam logic               RST_RUN_DEFAULT = 1'b0;
  localparam logic [ALPHA_W-1:0] RST_CONST_ALPHA = 18'd19661;
  localparam logic [ALPHA_W-1:0] RST_ALPHA_CAP   = 18'd65536;
  localparam logic [LAM_W-1:0]   RST_LAMBDA_SQ   = 22'd2621;
  localparam logic [NF_W-1:0]    RST_FLAVORS     = 3'd3;

  // Kind of evaluation an item travels with
  typedef enum logic [1:0] {
    KIND_CONST = 2'd0,
    KIND_BAND  = 2'd1,
    KIND_SPACE = 2'd2,
    KIND_TIME  = 2'd3
  } kind_t;

  // Request codes; the spare code behaves as the configured mode
  typedef enum logic [1:0] {
    REQ_CONFIG = 2'd0,
    REQ_CONST  = 2'd1,
    REQ_RUN    = 2'd2,
    REQ_SPARE  = 2'd3
  } req_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_RUN_DEFAULT = 3'd0,
    CFG_CONST_ALPHA = 3'd1,
    CFG_ALPHA_CAP   = 3'd2,
    CFG_LAMBDA_SQ   = 3'd3,
    CFG_FLAVORS     = 3'd4
  } cfg_idx_t;

  // CORDIC rotation angle of round i, Q24 radians
  function automatic logic [LOG_FRAC-1:0] atan_angle(input logic [4:0] i);
    logic [LOG_FRAC-1:0] a;
    case (i)
      5'd0: a = 24'd13176795;
      5'd1: a = 24'd7778716;
      5'd2: a = 24'd4110060;
      5'd3: a = 24'd2086331;
      5'd4: a = 24'd1047214;
      5'd5: a = 24'd524117;
      5'd6: a = 24'd262123;
      5'd7: a = 24'd131069;
      default: a = 24'd1 << (5'd24 - i);
    endcase
    return a;
  endfunction

  // Three times beta0: 33 - 2*nf
  function automatic logic [BETA_W-1:0] beta_num(input logic [NF_W-1:0] nf);
    return 6'd33 - {2'b00, nf, 1'b0};
  endfunction

endpackage

@@ src/qcd_rc_log2.sv @@
// Pipelined log2 in Q24 by repeated squaring of a normalized mantissa.
module qcd_rc_log2 (
  input  logic                          clk,
  input  logic [qcd_rc_pkg::MAG_W-1:0]  val_in,
  output logic [qcd_rc_pkg::LOG_W-1:0]  log_out
);
  import qcd_rc_pkg::*;

  logic [MAG_W-1:0]            val_r;
  logic [EXP_W-1:0]            exp_a_r;
  logic [EXP_W-1:0]            exp_nxt;
  logic [MAG_W+MANT_W-2:0]     wide_w;
  logic [MANT_W-1:0]           m_r   [0:LOG_FRAC];
  logic [EXP_W-1:0]            e_r   [0:LOG_FRAC];
  logic [LOG_FRAC-1:0]         f_r   [0:LOG_FRAC];
  logic [MANT_W-1:0]           m_nxt [1:LOG_FRAC];
  logic [LOG_FRAC-1:0]         f_nxt [1:LOG_FRAC];
  logic [2*MANT_W-1:0]         sq_w  [1:LOG_FRAC];

  // Find the position of the leading one
  always_comb begin
    exp_nxt = '0;
    for (int b = 1; b < MAG_W; b++) begin
      if (val_in[b]) begin
        exp_nxt = EXP_W'(b);
      end
    end
  end

  // Normalize so the leading one sits at bit 31
  assign wide_w = {val_r, {(MANT_W-1){1'b0}}} >> exp_a_r;

  // One fraction bit per round: square, renormalize
  always_comb begin
    for (int k = 1; k <= LOG_FRAC; k++) begin
      sq_w[k]  = m_r[k-1] * m_r[k-1];
      f_nxt[k] = f_r[k-1];
      if (sq_w[k][2*MANT_W-1]) begin
        m_nxt[k] = sq_w[k][2*MANT_W-1:MANT_W];
        f_nxt[k][LOG_FRAC-k] = 1'b1;
      end else begin
        m_nxt[k] = sq_w[k][2*MANT_W-2:MANT_W-1];
      end
    end
  end

  // Advance the stages
  always_ff @(posedge clk) begin
    val_r   <= val_in;
    exp_a_r <= exp_nxt;
    m_r[0]  <= wide_w[MANT_W-1:0];
    e_r[0]  <= exp_a_r;
    f_r[0]  <= '0;
    for (int k = 1; k <= LOG_FRAC; k++) begin
      m_r[k] <= m_nxt[k];
      e_r[k] <= e_r[k-1];
      f_r[k] <= f_nxt[k];
    end
  end

  assign log_out = {e_r[LOG_FRAC], f_r[LOG_FRAC]};

endmodule

@@ src/qcd_running_coupling_core.sv @@
// Top level of the one-loop running coupling core.
//
// Usage: drive in_q2 (signed Q2 scale, 16 fraction bits) and in_req_type with
// start high; the transaction is taken at any edge where start is high and
// busy is low. busy is high only while reset is applied, so one transaction
// may enter every cycle. Each transaction yields exactly one result:
// out_valid pulses for one cycle with out_alpha and out_capped.
// Throughput is one transaction per cycle. The pipeline holds the 24 squaring
// rounds of the log2 lanes, the 24 CORDIC rounds and the 19 restoring steps of
// the divider, one round per stage.
// Configuration: cfg_we with cfg_index and cfg_wdata writes one register;
// write only while no transaction is in flight.
// Reset (rst_n low, synchronous) clears the pipeline valid bits and loads
// register defaults. The receiver cannot stall; results are never held.
`include "qcd_running_coupling_core_assert.svh"

module qcd_running_coupling_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [qcd_rc_pkg::MAG_W-1:0]  in_q2,
  input  logic [1:0]                           in_req_type,
  output logic                                 out_valid,
  output logic [qcd_rc_pkg::ALPHA_W-1:0]       out_alpha,
  output logic                                 out_capped,
  input  logic                                 cfg_we,
  input  logic [2:0]                           cfg_index,
  input  logic [qcd_rc_pkg::CFG_W-1:0]         cfg_wdata
);
  import qcd_rc_pkg::*;

  // Configuration registers
  logic               run_default_r;
  logic [ALPHA_W-1:0] const_alpha_r;
  logic [ALPHA_W-1:0] alpha_cap_r;
  logic [LAM_W-1:0]   lambda_sq_r;
  logic [NF_W-1:0]    flavors_r;
  logic               busy_r;

  // Input stage
  logic [LAM_W-1:0]   lam_eff;
  logic               run_w;
  logic [MAG_W-1:0]   mag_w;
  kind_t              kind_w;
  logic               accept;
  logic               v0_r;
  kind_t              kind0_r;
  logic [MAG_W-1:0]   mag0_r;

  // Log lanes and their sideband
  logic [LOG_W-1:0]   log_q;
  logic [LOG_W-1:0]   log_l;
  logic               sb_v_r    [0:LOG_LAT-1];
  kind_t              sb_kind_r [0:LOG_LAT-1];

  // Log difference and scaling
  logic                  sl_v_r;
  kind_t                 sl_kind_r;
  logic signed [L_W-1:0] sl_l_r;
  logic                  sm_v_r;
  kind_t                 sm_kind_r;
  logic signed [L_W-1:0] sm_arg_r;
  logic [29:0]           scale_k;
  logic signed [63:0]    prod_w;

  // CORDIC stages
  logic                  c_v_r    [0:CORDIC_N];
  kind_t                 c_kind_r [0:CORDIC_N];
  logic signed [L_W-1:0] c_arg_r  [0:CORDIC_N];
  logic signed [CW-1:0]  cx_r     [0:CORDIC_N];
  logic signed [CW-1:0]  cy_r     [0:CORDIC_N];
  logic signed [ZW-1:0]  z_r      [0:CORDIC_N];
  logic signed [CW-1:0]  cx_nxt   [1:CORDIC_N];
  logic signed [CW-1:0]  cy_nxt   [1:CORDIC_N];
  logic signed [ZW-1:0]  z_nxt    [1:CORDIC_N];
  logic signed [ZW-1:0]  ang_w    [1:CORDIC_N];

  // Divider operand build
  logic signed [ZW:0]    d_s;
  logic [DW-1:0]         d_u;
  logic [BETA_W-1:0]     beta;
  kind_t                 sd_kind;
  logic [NUM_W-1:0]      sd_num;
  logic [DEN_W-1:0]      sd_den;

  // Divider stages
  logic                  dv_v_r    [0:DIV_N];
  kind_t                 dv_kind_r [0:DIV_N];
  logic [NUM_W-1:0]      dv_rem_r  [0:DIV_N];
  logic [DEN_W-1:0]      dv_den_r  [0:DIV_N];
  logic [ALPHA_W-1:0]    dv_q_r    [0:DIV_N];
  logic                  dv_over_r [0:DIV_N];
  logic [NUM_W-1:0]      rem_nxt   [1:DIV_N];
  logic [ALPHA_W-1:0]    q_nxt     [1:DIV_N];
  logic                  over_nxt  [1:DIV_N];
  logic [DIV_SH_W-1:0]   sh_w      [1:DIV_N];
  logic                  den_zero_w;

  // Output stage
  logic                  out_valid_r;
  logic [ALPHA_W-1:0]    out_alpha_r;
  logic                  out_capped_r;
  logic [ALPHA_W-1:0]    res_alpha;
  logic                  res_capped;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_default_r <= RST_RUN_DEFAULT;
      const_alpha_r <= RST_CONST_ALPHA;
      alpha_cap_r   <= RST_ALPHA_CAP;
      lambda_sq_r   <= RST_LAMBDA_SQ;
      flavors_r     <= RST_FLAVORS;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RUN_DEFAULT: run_default_r <= cfg_wdata[0];
        CFG_CONST_ALPHA: const_alpha_r <= cfg_wdata[ALPHA_W-1:0];
        CFG_ALPHA_CAP:   alpha_cap_r   <= cfg_wdata[ALPHA_W-1:0];
        CFG_LAMBDA_SQ:   lambda_sq_r   <= cfg_wdata[LAM_W-1:0];
        CFG_FLAVORS:     flavors_r     <= cfg_wdata[NF_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold busy only while in reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign accept  = start && !busy_r;
  assign lam_eff = (lambda_sq_r == '0) ? LAM_W'(1) : lambda_sq_r;

  // Pick mode and region of the scale
  always_comb begin
    case (req_t'(in_req_type))
      REQ_CONST: run_w = 1'b0;
      REQ_RUN:   run_w = 1'b1;
      default:   run_w = run_default_r;
    endcase
    mag_w = in_q2[MAG_W-1] ? MAG_W'(-in_q2) : MAG_W'(in_q2);
    if (!run_w) begin
      kind_w = KIND_CONST;
    end else if (in_q2[MAG_W-1] && (mag_w > MAG_W'(lam_eff))) begin
      kind_w = KIND_SPACE;
    end else if (!in_q2[MAG_W-1] && (in_q2 != '0)) begin
      kind_w = KIND_TIME;
    end else begin
      kind_w = KIND_BAND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
    kind0_r <= kind_w;
    mag0_r  <= mag_w;
  end

  // Log2 lanes for the scale and for lambda squared
  qcd_rc_log2 u_log_q (
    .clk     (clk),
    .val_in  (mag0_r),
    .log_out (log_q)
  );

  qcd_rc_log2 u_log_l (
    .clk     (clk),
    .val_in  (MAG_W'(lam_eff)),
    .log_out (log_l)
  );

  // Carry valid and kind alongside the log lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < LOG_LAT; s++) begin
        sb_v_r[s] <= 1'b0;
      end
    end else begin
      sb_v_r[0] <= v0_r;
      for (int s = 1; s < LOG_LAT; s++) begin
        sb_v_r[s] <= sb_v_r[s-1];
      end
    end
    sb_kind_r[0] <= kind0_r;
    for (int s = 1; s < LOG_LAT; s++) begin
      sb_kind_r[s] <= sb_kind_r[s-1];
    end
  end

  // Log ratio, then scale by ln2 or ln2/pi
  assign scale_k = (sl_kind_r == KIND_SPACE) ? LN2_Q30 : LN2PI_Q30;
  assign prod_w  = 64'(sl_l_r) * $signed({34'd0, scale_k});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sl_v_r <= 1'b0;
      sm_v_r <= 1'b0;
    end else begin
      sl_v_r <= sb_v_r[LOG_LAT-1];
      sm_v_r <= sl_v_r;
    end
    sl_kind_r <= sb_kind_r[LOG_LAT-1];
    sl_l_r    <= $signed({2'b00, log_q}) - $signed({2'b00, log_l});
    sm_kind_r <= sl_kind_r;
    sm_arg_r  <= L_W'(prod_w >>> 30);
  end

  // CORDIC vectoring rounds from (1, x)
  always_comb begin
    for (int i = 0; i < CORDIC_N; i++) begin
      ang_w[i+1] = $signed({{(ZW-LOG_FRAC){1'b0}}, atan_angle(5'(i))});
      if (!cy_r[i][CW-1]) begin
        cx_nxt[i+1] = cx_r[i] + (cy_r[i] >>> i);
        cy_nxt[i+1] = cy_r[i] - (cx_r[i] >>> i);
        z_nxt[i+1]  = z_r[i] + ang_w[i+1];
      end else begin
        cx_nxt[i+1] = cx_r[i] - (cy_r[i] >>> i);
        cy_nxt[i+1] = cy_r[i] + (cx_r[i] >>> i);
        z_nxt[i+1]  = z_r[i] - ang_w[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= CORDIC_N; i++) begin
        c_v_r[i] <= 1'b0;
      end
    end else begin
      c_v_r[0] <= sm_v_r;
      for (int i = 1; i <= CORDIC_N; i++) begin
        c_v_r[i] <= c_v_r[i-1];
      end
    end
    c_kind_r[0] <= sm_kind_r;
    c_arg_r[0]  <= sm_arg_r;
    cx_r[0]     <= CW'(1) <<< LOG_FRAC;
    cy_r[0]     <= CW'(sm_arg_r);
    z_r[0]      <= '0;
    for (int i = 1; i <= CORDIC_N; i++) begin
      c_kind_r[i] <= c_kind_r[i-1];
      c_arg_r[i]  <= c_arg_r[i-1];
      cx_r[i]     <= cx_nxt[i];
      cy_r[i]     <= cy_nxt[i];
      z_r[i]      <= z_nxt[i];
    end
  end

  // Build dividend and divisor for the region
  assign beta = beta_num(flavors_r);
  assign d_s  = $signed({3'b000, HALFPI_Q24}) - (ZW+1)'(z_r[CORDIC_N]);
  assign d_u  = d_s[ZW] ? '0 : d_s[DW-1:0];

  always_comb begin
    sd_kind = c_kind_r[CORDIC_N];
    sd_num  = '0;
    sd_den  = '0;
    case (c_kind_r[CORDIC_N])
      KIND_SPACE: begin
        if (c_arg_r[CORDIC_N] <= 0) begin
          sd_kind = KIND_BAND;
        end
        sd_num = NUM_W'(C12PI_Q24) << ALPHA_FRAC;
        sd_den = DEN_W'(beta) * DEN_W'(c_arg_r[CORDIC_N][29:0]);
      end
      KIND_TIME: begin
        sd_num = (NUM_W'(d_u) * NUM_W'(4'd12)) << ALPHA_FRAC;
        sd_den = DEN_W'(beta) << LOG_FRAC;
      end
      default: ;
    endcase
  end

  // Restoring division: first step flags quotient overflow, then one bit a step
  always_comb begin
    for (int k = 0; k < DIV_N; k++) begin
      sh_w[k+1]     = DIV_SH_W'(dv_den_r[k]) << (DIV_N - 1 - k);
      rem_nxt[k+1]  = dv_rem_r[k];
      q_nxt[k+1]    = dv_q_r[k];
      over_nxt[k+1] = dv_over_r[k];
      if (DIV_SH_W'(dv_rem_r[k]) >= sh_w[k+1]) begin
        if (k == 0) begin
          over_nxt[k+1] = 1'b1;
        end else begin
          rem_nxt[k+1] = dv_rem_r[k] - sh_w[k+1][NUM_W-1:0];
          q_nxt[k+1][DIV_N-1-k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_N; k++) begin
        dv_v_r[k] <= 1'b0;
      end
    end else begin
      dv_v_r[0] <= c_v_r[CORDIC_N];
      for (int k = 1; k <= DIV_N; k++) begin
        dv_v_r[k] <= dv_v_r[k-1];
      end
    end
    dv_kind_r[0] <= sd_kind;
    dv_rem_r[0]  <= sd_num;
    dv_den_r[0]  <= sd_den;
    dv_q_r[0]    <= '0;
    dv_over_r[0] <= 1'b0;
    for (int k = 1; k <= DIV_N; k++) begin
      dv_kind_r[k] <= dv_kind_r[k-1];
      dv_rem_r[k]  <= rem_nxt[k];
      dv_den_r[k]  <= dv_den_r[k-1];
      dv_q_r[k]    <= q_nxt[k];
      dv_over_r[k] <= over_nxt[k];
    end
  end

  // Select constant, band or capped quotient
  always_comb begin
    case (dv_kind_r[DIV_N])
      KIND_CONST: begin
        res_alpha  = const_alpha_r;
        res_capped = 1'b0;
      end
      KIND_BAND: begin
        res_alpha  = alpha_cap_r;
        res_capped = 1'b1;
      end
      default: begin
        if (dv_over_r[DIV_N] || (dv_q_r[DIV_N] > alpha_cap_r)) begin
          res_alpha  = alpha_cap_r;
          res_capped = 1'b1;
        end else begin
          res_alpha  = dv_q_r[DIV_N];
          res_capped = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v_r[DIV_N];
    end
    out_alpha_r  <= res_alpha;
    out_capped_r <= res_capped;
  end

  assign busy       = busy_r;
  assign out_valid  = out_valid_r;
  assign out_alpha  = out_alpha_r;
  assign out_capped = out_capped_r;

  // Running transaction entering the divider with a zero divisor
  assign den_zero_w = dv_v_r[0] && (dv_kind_r[0] == KIND_SPACE || dv_kind_r[0] == KIND_TIME)
                      && (dv_den_r[0] == '0);

  // A capped result always carries the cap value
  `QRC_ASSERT(a_capped_is_cap, clk, rst_n, out_valid_r && out_capped_r |-> out_alpha_r == alpha_cap_r)
  // A running transaction never reaches the divider with a zero divisor
  `QRC_NEVER(a_den_nonzero, clk, rst_n, den_zero_w)

endmodule
